// File: hdl/pfdn_pkg.sv
// ---------------------------------------------------------------------------
// pfdn_pkg: shared types and functions of the PCM downmix normalizer
// Holds the format and register codes, the frame handoff record and the
// conversion of one raw sample word into Q1.31.
// ---------------------------------------------------------------------------
`default_nettype none

package pfdn_pkg;

  // Sample format codes; codes above FMT_F32 decode as float32
  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S24 = 3'd2;
  localparam logic [2:0] FMT_S32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] CFG_IDX_FORMAT   = 8'd0;
  localparam logic [7:0] CFG_IDX_CHANNELS = 8'd1;

  // Reset values of the registers
  localparam logic [2:0] FORMAT_RESET   = FMT_S16;
  localparam logic [7:0] CHANNELS_RESET = 8'd1;

  // Widths
  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 40;
  localparam int CHAN_W   = 8;

  // Default channel limit
  localparam int MAX_CHANNELS_DEF = 255;

  // Frame handoff from the accumulator to the divider
  typedef struct packed {
    logic                    go;
    logic signed [SUM_W-1:0] sum;
    logic [CHAN_W-1:0]       divisor;
  } frame_t;

  // Convert float32 bits to Q1.31, truncating toward zero, saturating
  function automatic logic signed [SAMPLE_W-1:0] float_to_q31(input logic [31:0] bits);
    logic        neg;
    logic [7:0]  e;
    logic [23:0] mm;
    logic [7:0]  ee;
    logic [7:0]  r;
    logic [31:0] mag;
    logic [31:0] sat;
    neg = bits[31];
    e   = bits[30:23];
    mm  = {(e != 8'd0), bits[22:0]};
    ee  = (e == 8'd0) ? 8'd1 : e;
    sat = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = 32'd0;
    if (ee >= 8'd119) begin
      mag = {8'd0, mm} << (ee - 8'd119);
    end else begin
      r = 8'd119 - ee;
      mag = (r >= 8'd32) ? 32'd0 : ({8'd0, mm} >> r[4:0]);
    end
    if (e == 8'hFF) begin
      float_to_q31 = (bits[22:0] != 23'd0) ? 32'sd0 : $signed(sat);
    end else if (e >= 8'd127) begin
      float_to_q31 = $signed(sat);
    end else begin
      float_to_q31 = neg ? $signed(-mag) : $signed(mag);
    end
  endfunction

  // Left-justify one raw integer sample to Q1.31 per format; float32 is converted
  function automatic logic signed [SAMPLE_W-1:0] sample_to_q31(input logic [2:0]  fmt,
                                                               input logic [31:0] raw);
    logic signed [SAMPLE_W-1:0] q;
    unique case (fmt)
      FMT_U8:  q = $signed({~raw[7], raw[6:0], 24'd0});
      FMT_S16: q = $signed({raw[15:0], 16'd0});
      FMT_S24: q = $signed({raw[23:0], 8'd0});
      FMT_S32: q = $signed(raw);
      default: q = float_to_q31(raw);
    endcase
    sample_to_q31 = q;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pcm_frame_downmix_normalizer.sv
// ---------------------------------------------------------------------------
// pcm_frame_downmix_normalizer: PCM byte stream to mono Q1.31 frame mean
// Assembles little-endian samples in the configured format, converts them
// to Q1.31, sums one frame of channels and emits the truncated mean.
// ---------------------------------------------------------------------------
//
//  channel   direction  payload                         handshake
//  s_axis    in         tdata: data_byte, tlast: eod    tvalid/tready
//  m_axis    out        tdata: mean_sample (Q1.31)      tvalid/tready
//  cfg       in         cfg_index, cfg_data             cfg_valid/cfg_ready
//
//  A byte that does not complete a frame leaves the input open for the next byte.
//  A byte that completes a frame starts a 40-step bit-serial divide; the
//  input stays closed until the mean enters the output register, longer if
//  the previous mean still waits in the output register.
//  Reset sets format to signed 16 and one channel; a register write drops
//  any partial sample or frame. The output register holds under m_axis_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module pcm_frame_downmix_normalizer #(
  parameter int MAX_CHANNELS = pfdn_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] mean_sample
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import pfdn_pkg::*;

  localparam int CLAMP_INT = (MAX_CHANNELS > 255) ? 255 : MAX_CHANNELS;
  localparam logic [CHAN_W-1:0] CLAMP = CHAN_W'(CLAMP_INT);

  logic [2:0]        fmt;
  logic [CHAN_W-1:0] chan;
  logic [CHAN_W-1:0] nch;
  logic              cfg_wr;
  logic              clear;
  logic              accept;
  logic              busy;
  frame_t            frame;
  logic signed [SAMPLE_W-1:0] mean;

  assign cfg_ready     = 1'b1;
  assign cfg_wr        = cfg_valid && cfg_ready;
  assign clear         = cfg_wr && (cfg_index == CFG_IDX_FORMAT ||
                                    cfg_index == CFG_IDX_CHANNELS);
  assign s_axis_tready = !busy && !frame.go;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = mean;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt  <= FORMAT_RESET;
      chan <= CHANNELS_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_IDX_FORMAT) begin
        fmt <= cfg_data[2:0];
      end else if (cfg_index == CFG_IDX_CHANNELS) begin
        chan <= cfg_data;
      end
    end
  end

  // Effective channel count: zero acts as one, clamp at the limit
  always_comb begin
    if (chan == '0) begin
      nch = CHAN_W'(1);
    end else if (chan > CLAMP) begin
      nch = CLAMP;
    end else begin
      nch = chan;
    end
  end

  pfdn_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .clear       (clear),
    .fmt         (fmt),
    .nch         (nch),
    .accept      (accept),
    .data_byte   (s_axis_tdata),
    .end_of_data (s_axis_tlast),
    .frame       (frame)
  );

  pfdn_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .busy      (busy),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (mean)
  );

endmodule

`default_nettype wire

// File: hdl/pfdn_accum.sv
// ---------------------------------------------------------------------------
// pfdn_accum: byte gather and frame accumulator
// Gathers little-endian bytes into samples, converts each sample to Q1.31
// and sums the channels of a frame; hands the finished sum to the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdn_accum (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    clear,
  input  wire logic [2:0]              fmt,
  input  wire logic [pfdn_pkg::CHAN_W-1:0] nch,
  input  wire logic                    accept,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    end_of_data,
  output pfdn_pkg::frame_t             frame
);
  import pfdn_pkg::*;

  logic [23:0]             gather;
  logic [1:0]              bidx;
  logic [CHAN_W-1:0]       cidx;
  logic signed [SUM_W-1:0] sum;

  logic [1:0]                 last_idx;
  logic [31:0]                raw;
  logic signed [SAMPLE_W-1:0] q;
  logic signed [SUM_W-1:0]    sum_next;
  logic                       frame_done;

  // Index of the byte that completes a sample
  always_comb begin
    unique case (fmt)
      FMT_U8:  last_idx = 2'd0;
      FMT_S16: last_idx = 2'd1;
      FMT_S24: last_idx = 2'd2;
      default: last_idx = 2'd3;
    endcase
  end

  // Merge the incoming byte and convert the completed sample
  always_comb begin
    raw        = {8'd0, gather} | ({24'd0, data_byte} << {bidx, 3'b000});
    q          = sample_to_q31(fmt, raw);
    sum_next   = sum + {{(SUM_W-SAMPLE_W){q[SAMPLE_W-1]}}, q};
    frame_done = ({1'b0, cidx} + 9'd1) >= {1'b0, nch};
  end

  // Advance gather, channel and sum state per accepted byte; hand off the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      gather        <= '0;
      bidx          <= '0;
      cidx          <= '0;
      sum           <= '0;
      frame.go      <= 1'b0;
      frame.sum     <= '0;
      frame.divisor <= '0;
    end else begin
      frame.go <= 1'b0;
      if (clear) begin
        gather <= '0;
        bidx   <= '0;
        cidx   <= '0;
        sum    <= '0;
      end else if (accept) begin
        if (bidx != last_idx) begin
          gather <= raw[23:0];
          bidx   <= bidx + 2'd1;
        end else begin
          gather <= '0;
          bidx   <= '0;
          if (frame_done) begin
            frame.go      <= 1'b1;
            frame.sum     <= sum_next;
            frame.divisor <= nch;
            cidx          <= '0;
            sum           <= '0;
          end else begin
            cidx <= cidx + 1'b1;
            sum  <= sum_next;
          end
        end
        // Drop any partial sample or frame after the final byte
        if (end_of_data) begin
          gather <= '0;
          bidx   <= '0;
          cidx   <= '0;
          sum    <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/pfdn_divider.sv
// ---------------------------------------------------------------------------
// pfdn_divider: bit-serial signed divide and output register
// Divides the frame sum by the channel count one quotient bit per cycle,
// truncating toward zero, and holds the mean until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdn_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfdn_pkg::frame_t  frame,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [pfdn_pkg::SAMPLE_W-1:0] out_data
);
  import pfdn_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } div_state_t;

  div_state_t        state;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  mag;
  logic [CHAN_W-1:0] rem;
  logic [CHAN_W-1:0] dvs;
  logic              neg;

  logic [CHAN_W:0]      trial;
  logic                 qbit;
  logic [SAMPLE_W-1:0]  quot;
  logic                 out_free;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial    = {rem, mag[SUM_W-1]};
    qbit     = trial >= {1'b0, dvs};
    quot     = mag[SAMPLE_W-1:0];
    out_free = !out_valid || out_ready;
  end

  assign busy = (state != ST_IDLE);

  // Sequence load, serial steps and result handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (frame.go) begin
            cnt   <= CNT_W'(SUM_W);
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: magnitude shift register, remainder and result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && frame.go) begin
      neg <= frame.sum[SUM_W-1];
      mag <= frame.sum[SUM_W-1] ? SUM_W'(-frame.sum) : SUM_W'(frame.sum);
      rem <= '0;
      dvs <= frame.divisor;
    end else if (state == ST_RUN) begin
      rem <= qbit ? CHAN_W'(trial - {1'b0, dvs}) : trial[CHAN_W-1:0];
      mag <= {mag[SUM_W-2:0], qbit};
    end
    if (state == ST_HOLD && out_free) begin
      out_data <= neg ? $signed(-quot) : $signed(quot);
    end
  end

endmodule

`default_nettype wire

// File: hdl/pfdn_checker.sv
// ---------------------------------------------------------------------------
// pfdn_checker: port-level checks of the downmix normalizer
// Watches the top-level ports for output hold, reset behavior and the
// closing of the input while a mean is computed.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // Hold a stalled mean unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed or dropped");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A new mean appears only after the input was closed for the divide
  a_new_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output item without a preceding divide");

  // Back-to-back means only come from a divide that was waiting
  a_refill_after_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> (!m_axis_tvalid || $past(!s_axis_tready)))
    else $error("output refilled without a pending divide");

endmodule

bind pcm_frame_downmix_normalizer pfdn_checker u_pfdn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
